### design/phm_pkg.sv
// ----------------------------------------------------------------------------
// phm_pkg
// shared constants, command codes and state type for the position heat map
// ----------------------------------------------------------------------------
`default_nettype none

package phm_pkg;

	// grid geometry
	localparam int GRID_COLUMNS = 33;
	localparam int GRID_ROWS    = 26;
	localparam int CELL_TOTAL   = GRID_COLUMNS * GRID_ROWS;

	// widths derived from the grid
	localparam int IDX_W = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
	localparam int CNT_W = $clog2(CELL_TOTAL + 1);
	localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	// port field widths
	localparam int CMD_W   = 2;
	localparam int POS_W   = 16;
	localparam int OIDX_W  = 10;
	localparam int COUNT_W = 16;
	localparam int OLEN_W  = 10;

	// binning
	localparam int CELL_MM     = 300;
	localparam int ORIGIN_X_MM = -4800;
	localparam int OFF_W       = POS_W + 1;
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP       = ((2 ** RECIP_SHIFT) + CELL_MM - 1) / CELL_MM;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = POS_W + RECIP_W;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_HIT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN,
		ST_ADDR,
		ST_HIT_WB,
		ST_SCAN_HEAD,
		ST_SCAN_WALK,
		ST_RESULT
	} phm_state_t;

endpackage

`default_nettype wire

### design/position_heatmap_with_rle_readout_top.sv
// ----------------------------------------------------------------------------
// position_heatmap_with_rle_readout_top
// 2d hit histogram over a 33 x 26 grid of 16-bit counters, with run-length
// readout of the counters in row-major order
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | sink      | in_valid / in_ready | cmd, x_mm, y_mm
//  out     | source    | out_valid/out_ready | bin_index, count_value, run_length,
//          |           |                     | last_run
//
//  one item at a time; in_ready is high whenever the sequencer is idle, also
//  while a finished item still waits on the output register
//  hit: offset, reciprocal multiply, index + ram read, write back, result; the
//  write back waits on the registered ram read of the read-modify-write
//  read next run: head, a walk comparing one counter per cycle, result; the
//  walk ends without a mismatching counter when the run reaches the last cell
//  clear: one ram entry zeroed per cycle over all CELL_TOTAL (858), then result
//  after reset a clearing pass over all CELL_TOTAL (858) entries runs before in_ready
//  a stalled output holds the sequencer in its result state
// ----------------------------------------------------------------------------
`default_nettype none

module position_heatmap_with_rle_readout_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [phm_pkg::CMD_W-1:0]      cmd,
	input  wire logic signed [phm_pkg::POS_W-1:0] x_mm,
	input  wire logic signed [phm_pkg::POS_W-1:0] y_mm,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [phm_pkg::OIDX_W-1:0]     bin_index,
	output logic      [phm_pkg::COUNT_W-1:0]    count_value,
	output logic      [phm_pkg::OLEN_W-1:0]     run_length,
	output logic                                last_run
);

	import phm_pkg::*;

	// sequencer state
	phm_state_t state_q, state_d;

	// clearing pass
	logic [IDX_W-1:0] clr_q;
	logic             clr_res_q;   // clear came from a command, so report it

	// hit path
	logic signed [OFF_W-1:0] off_x_q, off_y_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [IDX_W-1:0]        idx_q;

	// scan path
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   start_q;
	logic [CNT_W-1:0]   end_q;
	logic [COUNT_W-1:0] val_q;

	// pending result
	logic [OIDX_W-1:0]  res_idx_q;
	logic [COUNT_W-1:0] res_cnt_q;
	logic [OLEN_W-1:0]  res_len_q;
	logic               res_last_q;

	// output register
	logic               out_valid_q;
	logic [OIDX_W-1:0]  out_idx_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [OLEN_W-1:0]  out_len_q;
	logic               out_last_q;

	// ram ports
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [COUNT_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [COUNT_W-1:0] ram_rdata;

	// combinational helpers
	logic                    accept;
	logic [IDX_W-1:0]        start_c;
	logic signed [OFF_W-1:0] off_x_c, off_y_c;
	logic [POS_W-1:0]        ux, uy;
	logic [PROD_W-1:0]       prod_x, prod_y;
	logic [QUO_W-1:0]        qx, qy;
	logic [COL_W-1:0]        col_c;
	logic [ROW_W-1:0]        row_c;
	logic [IDX_W-1:0]        idx_c;
	logic [COUNT_W-1:0]      inc_c;
	logic [CNT_W-1:0]        end_nxt;
	logic                    fin;
	logic [CNT_W-1:0]        fin_end;
	logic [COUNT_W-1:0]      fin_val;
	logic                    fin_last;
	logic                    out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// scan start, an out of range position restarts at cell zero
	assign start_c = (CNT_W'(scan_q) >= CNT_W'(CELL_TOTAL)) ? '0 : scan_q;

	// position offsets from the grid origin
	assign off_x_c = OFF_W'(x_mm) + OFF_W'(ORIGIN_X_MM * -1);
	assign off_y_c = OFF_W'(y_mm);

	// divide by the cell size through a reciprocal multiply, negatives bin to 0
	assign ux     = off_x_q[OFF_W-1] ? '0 : off_x_q[POS_W-1:0];
	assign uy     = off_y_q[OFF_W-1] ? '0 : off_y_q[POS_W-1:0];
	assign prod_x = PROD_W'(ux) * PROD_W'(RECIP);
	assign prod_y = PROD_W'(uy) * PROD_W'(RECIP);
	assign qx     = prod_x[RECIP_SHIFT +: QUO_W];
	assign qy     = prod_y[RECIP_SHIFT +: QUO_W];

	// clamp to the last column and row
	assign col_c = (qx >= QUO_W'(GRID_COLUMNS)) ? COL_W'(GRID_COLUMNS - 1) : COL_W'(qx);
	assign row_c = (qy >= QUO_W'(GRID_ROWS)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(qy);

	// row-major cell index
	assign idx_c = IDX_W'(row_q) * IDX_W'(GRID_COLUMNS) + IDX_W'(col_q);

	// saturating increment of the cell read back
	assign inc_c = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

	assign end_nxt = end_q + 1'b1;

	// next state, ram access and run termination
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = start_c;
		fin       = 1'b0;
		fin_end   = end_q;
		fin_val   = val_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (CNT_W'(clr_q) == CNT_W'(CELL_TOTAL - 1)) begin
					state_d = clr_res_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (cmd)
						CMD_HIT:   state_d = ST_BIN;
						CMD_READ:  state_d = ST_SCAN_HEAD;
						CMD_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_BIN: begin
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				ram_raddr = idx_c;
				state_d   = ST_HIT_WB;
			end
			ST_HIT_WB: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = inc_c;
				state_d   = ST_RESULT;
			end
			ST_SCAN_HEAD: begin
				// first cell of the run is on the read port
				fin_val = ram_rdata;
				if (end_q == CNT_W'(CELL_TOTAL)) begin
					fin     = 1'b1;
					state_d = ST_RESULT;
				end else begin
					ram_raddr = end_q[IDX_W-1:0];
					state_d   = ST_SCAN_WALK;
				end
			end
			ST_SCAN_WALK: begin
				if (ram_rdata == val_q) begin
					if (end_nxt == CNT_W'(CELL_TOTAL)) begin
						fin     = 1'b1;
						fin_end = end_nxt;
						state_d = ST_RESULT;
					end else begin
						ram_raddr = end_nxt[IDX_W-1:0];
					end
				end else begin
					fin     = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fin_last = (fin_end == CNT_W'(CELL_TOTAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			clr_res_q <= 1'b0;
			scan_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && cmd == CMD_CLEAR) begin
				clr_q     <= '0;
				clr_res_q <= 1'b1;
				scan_q    <= '0;
			end
			if (fin) begin
				scan_q <= fin_last ? '0 : fin_end[IDX_W-1:0];
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			off_x_q <= off_x_c;
			off_y_q <= off_y_c;
			start_q <= start_c;
			end_q   <= CNT_W'(start_c) + 1'b1;
			// clear and the unused code report all zero
			res_idx_q  <= '0;
			res_cnt_q  <= '0;
			res_len_q  <= '0;
			res_last_q <= 1'b0;
		end
		if (state_q == ST_BIN) begin
			col_q <= col_c;
			row_q <= row_c;
		end
		if (state_q == ST_ADDR) begin
			idx_q <= idx_c;
		end
		if (state_q == ST_HIT_WB) begin
			res_idx_q <= OIDX_W'(idx_q);
			res_cnt_q <= inc_c;
		end
		if (state_q == ST_SCAN_HEAD) begin
			val_q <= ram_rdata;
		end
		if (state_q == ST_SCAN_WALK && !fin) begin
			end_q <= end_nxt;
		end
		if (fin) begin
			res_idx_q  <= OIDX_W'(start_q);
			res_cnt_q  <= fin_val;
			res_len_q  <= OLEN_W'(fin_end - CNT_W'(start_q));
			res_last_q <= fin_last;
		end
	end

	// output register, loaded once the previous item has gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_idx_q  <= res_idx_q;
			out_cnt_q  <= res_cnt_q;
			out_len_q  <= res_len_q;
			out_last_q <= res_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bin_index   = out_idx_q;
	assign count_value = out_cnt_q;
	assign run_length  = out_len_q;
	assign last_run    = out_last_q;

	// counter store
	phm_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(CELL_TOTAL)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

### design/phm_ram.sv
// ----------------------------------------------------------------------------
// phm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module phm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/phm_checker.sv
// ----------------------------------------------------------------------------
// phm_checker
// port-level checks for the position heat map, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module phm_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [phm_pkg::OIDX_W-1:0]        bin_index,
	input wire logic [phm_pkg::COUNT_W-1:0]       count_value,
	input wire logic [phm_pkg::OLEN_W-1:0]        run_length,
	input wire logic                              last_run
);

	import phm_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_index) &&
		$stable(count_value) && $stable(run_length) && $stable(last_run))
		else $error("result changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the item finished");

	// the last run ends exactly at the final cell
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_run |->
		OIDX_W'(bin_index + run_length) == OIDX_W'(CELL_TOTAL))
		else $error("last run does not end at the last cell");

	// hit, clear and unused results never flag a last run
	a_no_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_length == '0 |-> !last_run)
		else $error("last run flagged on a result without a run");

endmodule

bind position_heatmap_with_rle_readout_top phm_checker u_phm_checker (.*);

`default_nettype wire
